FILE: src/stencil_to_csr_row_generator_core_assert.svh
// Assertion macros shared by the block. The enclosing scope must provide clk and rst_n.
`ifndef STENCIL_TO_CSR_ROW_GENERATOR_CORE_ASSERT_SVH
`define STENCIL_TO_CSR_ROW_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2CSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2csr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define S2CSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2csr assertion failed");

`endif

FILE: src/s2csr_pkg.sv
`timescale 1ns / 1ps

package s2csr_pkg;

    localparam int COLUMN_W   = 19;
    localparam int ROW_PTR_W  = 23;
    localparam int INDEX_W    = 5;
    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 5;

    // Input item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_DIM_X         = 3'd0;
    localparam logic [2:0] REG_DIM_Y         = 3'd1;
    localparam logic [2:0] REG_DIM_Z         = 3'd2;
    localparam logic [2:0] REG_STENCIL_WIDTH = 3'd3;
    localparam logic [2:0] REG_KINETIC_SCALE = 3'd4;

    // Side information that travels with one entry through the datapath.
    typedef struct packed {
        logic                        row_last;
        logic [ROW_PTR_W-1:0]        row_pointer;
        logic [COLUMN_W-1:0]         column;
        logic signed [DATA_W-1:0]    pot_term;
    } s2csr_tag_t;

endpackage

FILE: src/s2csr_if.sv
`timescale 1ns / 1ps

interface s2csr_item_if
    import s2csr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [INDEX_W-1:0]       coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] potential;

    modport source (output valid, kind, coef_index, coef_value, potential, input ready);
    modport sink (input valid, kind, coef_index, coef_value, potential, output ready);
endinterface

interface s2csr_entry_if
    import s2csr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic [COLUMN_W-1:0]          column;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic [ROW_PTR_W-1:0]         row_pointer;
    logic                         row_last;

    modport source (output valid, column, entry_value, row_pointer, row_last, input ready);
    modport sink (input valid, column, entry_value, row_pointer, row_last, output ready);
endinterface

FILE: src/stencil_to_csr_row_generator_core.sv
`timescale 1ns / 1ps

// Stencil-to-CSR row generator. Program dim_x, dim_y, dim_z, stencil_width and
// kinetic_scale over APB (byte addresses 0, 4, 8, 12, 16), stream the stencil
// coefficients in as load items, then send one point item per grid point in
// x-major, y-middle, z-minor order. Each point yields one entry per in-bounds
// neighbor in stencil order, and the last entry of a row carries row_last and
// the row pointer. A point has 1 to 27 in-bounds neighbors; no new item is
// taken until the last of them is issued, because a single sequencer steps
// through the neighbors and feeds one shared coefficient read and multiplier
// each cycle unless the pipeline stalls, which it does as a whole while the
// output transfer is held off. Entries pass through the coefficient read,
// product and output registers. Writing a geometry register restarts the frame.
module stencil_to_csr_row_generator_core
    import s2csr_pkg::*;
#(
    parameter int MAX_DIM    = 64,
    parameter int MAX_WIDTH  = 3,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    s2csr_item_if.sink            items,
    s2csr_entry_if.source         entries,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

`include "stencil_to_csr_row_generator_core_assert.svh"

    localparam int COEF_DEPTH = MAX_WIDTH * MAX_WIDTH * MAX_WIDTH;
    localparam int ADDR_W     = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam bit DEPTH_POW2 = (COEF_DEPTH & (COEF_DEPTH - 1)) == 0;
    localparam int HALF_MAX   = MAX_WIDTH / 2;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int EFF_W      = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Configuration registers.
    logic [6:0]        dim_x_reg, dim_y_reg, dim_z_reg;
    logic [1:0]        sw_reg;
    logic [DATA_W-1:0] scale_reg;

    state_t               state_reg;
    logic [POS_W-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [COLUMN_W-1:0]  point_reg;
    logic [ROW_PTR_W-1:0] count_reg;
    logic [1:0]           ox_reg, oy_reg, oz_reg;
    logic [1:0]           ox_min_reg, oy_min_reg, oz_min_reg;
    logic [1:0]           ox_max_reg, oy_max_reg, oz_max_reg;
    logic [DATA_W-1:0]    pot_reg;
    logic [COLUMN_W-1:0]  stride_reg;
    logic [COLUMN_W-1:0]  nz_col_reg;

    logic [DATA_W-1:0]    coef_mem [COEF_DEPTH];
    logic [DATA_W-1:0]    coef_rd_reg;
    logic                 s1_valid_reg;
    s2csr_tag_t           s1_tag_reg;

    logic [EFF_W-1:0]     nx, ny, nz;
    logic                 half;
    logic                 cfg_we, geom_we;
    logic                 accept, point_acc, load_we;
    logic                 issue, adv, last_step;
    logic [INDEX_W-1:0]   sidx;
    logic [ADDR_W-1:0]    ridx;
    logic [COLUMN_W-1:0]  term_x, term_y, term_z, col_next;
    logic                 diag;
    logic [ROW_PTR_W-1:0] count_inc;
    s2csr_tag_t           tag_next;
    logic                 dp_valid;
    s2csr_tag_t           dp_tag;
    logic signed [VALUE_BITS-1:0] dp_value;

    function automatic logic [EFF_W-1:0] eff_dim(input logic [6:0] d);
        if (d == 7'd0)
        begin
            return EFF_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            return EFF_W'(MAX_DIM);
        end
        return EFF_W'(d);
    endfunction

    function automatic logic [1:0] off_min(input logic h, input logic [POS_W-1:0] p);
        return (h && p == '0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] off_max(input logic h, input logic [POS_W-1:0] p,
                                           input logic [EFF_W-1:0] n);
        if (!h)
        begin
            return 2'd0;
        end
        return (EFF_W'(p) + EFF_W'(1) == n) ? 2'd1 : 2'd2;
    endfunction

    // Offset of a neighbor along one axis: offset 2 steps forward, and offset 0 steps back when the half width is one.
    function automatic logic [COLUMN_W-1:0] axis_term(input logic h, input logic [1:0] o,
                                                      input logic [COLUMN_W-1:0] s);
        if (h && o == 2'd0)
        begin
            return COLUMN_W'(0) - s;
        end
        else if (o == 2'd2)
        begin
            return s;
        end
        return '0;
    endfunction

    assign nx   = eff_dim(dim_x_reg);
    assign ny   = eff_dim(dim_y_reg);
    assign nz   = eff_dim(dim_z_reg);
    assign half = (HALF_MAX > 0) && sw_reg[1];

    // APB
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign geom_we = cfg_we && (paddr[4:2] == REG_DIM_X || paddr[4:2] == REG_DIM_Y ||
                                paddr[4:2] == REG_DIM_Z || paddr[4:2] == REG_STENCIL_WIDTH);

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DIM_X:         prdata = {25'd0, dim_x_reg};
            REG_DIM_Y:         prdata = {25'd0, dim_y_reg};
            REG_DIM_Z:         prdata = {25'd0, dim_z_reg};
            REG_STENCIL_WIDTH: prdata = {30'd0, sw_reg};
            REG_KINETIC_SCALE: prdata = scale_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= 7'd1;
            dim_y_reg <= 7'd1;
            dim_z_reg <= 7'd1;
            sw_reg    <= 2'd3;
            scale_reg <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_DIM_X:         dim_x_reg <= pwdata[6:0];
                REG_DIM_Y:         dim_y_reg <= pwdata[6:0];
                REG_DIM_Z:         dim_z_reg <= pwdata[6:0];
                REG_STENCIL_WIDTH: sw_reg    <= pwdata[1:0];
                REG_KINETIC_SCALE: scale_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    // Handshake and sequencer control.
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign point_acc   = accept && items.kind == KIND_POINT;
    assign load_we     = accept && items.kind == KIND_LOAD && int'(items.coef_index) < COEF_DEPTH;
    assign issue       = (state_reg == ST_RUN) && adv;
    assign last_step   = ox_reg == ox_max_reg && oy_reg == oy_max_reg && oz_reg == oz_max_reg;

    assign sidx = half ? (5'(ox_reg) * 5'd9 + 5'(oy_reg) * 5'd3 + 5'(oz_reg)) : '0;
    assign ridx = ADDR_W'(DEPTH_POW2 ? (sidx & INDEX_W'(COEF_DEPTH - 1)) : sidx);
    assign diag = half ? (ox_reg == 2'd1 && oy_reg == 2'd1 && oz_reg == 2'd1) : 1'b1;

    assign term_x   = axis_term(half, ox_reg, stride_reg);
    assign term_y   = axis_term(half, oy_reg, nz_col_reg);
    assign term_z   = axis_term(half, oz_reg, COLUMN_W'(1));
    assign col_next = point_reg + term_x + term_y + term_z + COLUMN_W'(1);
    assign count_inc = count_reg + ROW_PTR_W'(1);

    always_comb
    begin
        tag_next.row_last    = last_step;
        tag_next.row_pointer = last_step ? (count_inc + ROW_PTR_W'(1)) : '0;
        tag_next.column      = col_next;
        tag_next.pot_term    = diag ? pot_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        stride_reg <= COLUMN_W'(ny) * COLUMN_W'(nz);
        nz_col_reg <= COLUMN_W'(nz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            point_reg  <= '0;
            count_reg  <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
            ox_min_reg <= '0;
            oy_min_reg <= '0;
            oz_min_reg <= '0;
            ox_max_reg <= '0;
            oy_max_reg <= '0;
            oz_max_reg <= '0;
        end
        else if (geom_we)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            point_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (point_acc)
                    begin
                        ox_reg     <= off_min(half, pos_x_reg);
                        oy_reg     <= off_min(half, pos_y_reg);
                        oz_reg     <= off_min(half, pos_z_reg);
                        ox_min_reg <= off_min(half, pos_x_reg);
                        oy_min_reg <= off_min(half, pos_y_reg);
                        oz_min_reg <= off_min(half, pos_z_reg);
                        ox_max_reg <= off_max(half, pos_x_reg, nx);
                        oy_max_reg <= off_max(half, pos_y_reg, ny);
                        oz_max_reg <= off_max(half, pos_z_reg, nz);
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        count_reg <= count_inc;
                        if (oz_reg != oz_max_reg)
                        begin
                            oz_reg <= oz_reg + 2'd1;
                        end
                        else
                        begin
                            oz_reg <= oz_min_reg;
                            if (oy_reg != oy_max_reg)
                            begin
                                oy_reg <= oy_reg + 2'd1;
                            end
                            else
                            begin
                                oy_reg <= oy_min_reg;
                                ox_reg <= ox_reg + 2'd1;
                            end
                        end
                        if (last_step)
                        begin
                            state_reg <= ST_IDLE;
                            point_reg <= point_reg + COLUMN_W'(1);
                            if (EFF_W'(pos_z_reg) + EFF_W'(1) != nz)
                            begin
                                pos_z_reg <= pos_z_reg + POS_W'(1);
                            end
                            else
                            begin
                                pos_z_reg <= '0;
                                if (EFF_W'(pos_y_reg) + EFF_W'(1) != ny)
                                begin
                                    pos_y_reg <= pos_y_reg + POS_W'(1);
                                end
                                else
                                begin
                                    pos_y_reg <= '0;
                                    if (EFF_W'(pos_x_reg) + EFF_W'(1) != nx)
                                    begin
                                        pos_x_reg <= pos_x_reg + POS_W'(1);
                                    end
                                    else
                                    begin
                                        // End of grid: the next point starts a new matrix.
                                        pos_x_reg <= '0;
                                        point_reg <= '0;
                                        count_reg <= '0;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_acc)
        begin
            pot_reg <= items.potential;
        end
    end

    // Coefficient store with registered read.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            coef_mem[ADDR_W'(items.coef_index)] <= items.coef_value;
        end
        if (issue)
        begin
            coef_rd_reg <= coef_mem[ridx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_tag_reg <= tag_next;
        end
    end

    s2csr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (s1_valid_reg),
        .step_tag   (s1_tag_reg),
        .coef       (coef_rd_reg),
        .scale      (scale_reg),
        .out_ready  (entries.ready),
        .adv        (adv),
        .out_valid  (dp_valid),
        .out_tag    (dp_tag),
        .out_value  (dp_value)
    );

    assign entries.valid       = dp_valid;
    assign entries.column      = dp_tag.column;
    assign entries.entry_value = dp_value;
    assign entries.row_pointer = dp_tag.row_pointer;
    assign entries.row_last    = dp_tag.row_last;

    `S2CSR_ASSERT_IMP(a_rp_only_last, entries.valid && !entries.row_last,
                      entries.row_pointer == '0)
    `S2CSR_ASSERT_NEXT(a_point_runs, point_acc && !geom_we, state_reg == ST_RUN)
    `S2CSR_ASSERT_IMP(a_offsets_bound, state_reg == ST_RUN,
                      oz_reg <= oz_max_reg && oy_reg <= oy_max_reg && ox_reg <= ox_max_reg)
    `S2CSR_ASSERT_IMP(a_pos_in_grid, !geom_we,
                      EFF_W'(pos_x_reg) < nx && EFF_W'(pos_y_reg) < ny && EFF_W'(pos_z_reg) < nz)

endmodule

FILE: src/s2csr_datapath.sv
`timescale 1ns / 1ps

module s2csr_datapath
    import s2csr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_valid,
    input  s2csr_tag_t                   step_tag,
    input  logic signed [DATA_W-1:0]     coef,
    input  logic signed [DATA_W-1:0]     scale,
    input  logic                         out_ready,
    output logic                         adv,
    output logic                         out_valid,
    output s2csr_tag_t                   out_tag,
    output logic signed [VALUE_BITS-1:0] out_value
);

    localparam int PROD_W  = 2 * DATA_W;
    localparam int SHIFT_W = PROD_W - 18;
    localparam int SUM_W   = 49;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;
    s2csr_tag_t                s2_tag_reg;
    logic                      out_valid_reg;
    s2csr_tag_t                out_tag_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;

    logic signed [SHIFT_W-1:0] shifted;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_BITS-1:0] value_next;

    assign adv = !out_valid_reg || out_ready;

    // Divide by four and drop to Q16.16 with round half up, then add the potential.
    assign shifted = s2_prod_reg[PROD_W-1:18];
    assign sum = {{(SUM_W - SHIFT_W){shifted[SHIFT_W-1]}}, shifted}
               + {{(SUM_W - DATA_W){s2_tag_reg.pot_term[DATA_W-1]}}, s2_tag_reg.pot_term}
               + {{(SUM_W - 1){1'b0}}, s2_prod_reg[17]};

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            value_next = SAT_HI[VALUE_BITS-1:0];
        end
        else if (sum < SAT_LO)
        begin
            value_next = SAT_LO[VALUE_BITS-1:0];
        end
        else
        begin
            value_next = sum[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= step_valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg   <= scale * coef;
            s2_tag_reg    <= step_tag;
            out_tag_reg   <= s2_tag_reg;
            out_value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_value = out_value_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import s2csr_pkg::*;
();

    localparam int STENCIL_DEPTH = 27;
    localparam int CENTER_INDEX = 13;
    localparam int GRID_LIMIT = 64;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [COLUMN_W-1:0]      column;
        logic signed [DATA_W-1:0] value;
        logic [ROW_PTR_W-1:0]     row_pointer;
        logic                     row_last;
    } csr_entry_t;

    typedef struct packed {
        logic                     kind;
        logic [INDEX_W-1:0]       coef_index;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] potential;
    } grid_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    s2csr_item_if item_ch ();
    s2csr_entry_if #(.VALUE_BITS(32)) entry_ch ();

    stencil_to_csr_row_generator_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .entries (entry_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the block's configuration and frame state.
    logic [6:0]               dim_x_reg;
    logic [6:0]               dim_y_reg;
    logic [6:0]               dim_z_reg;
    logic [1:0]               width_reg;
    logic signed [DATA_W-1:0] scale_reg;
    logic signed [DATA_W-1:0] stencil_coef [STENCIL_DEPTH];
    int                       pos_x;
    int                       pos_y;
    int                       pos_z;
    logic [ROW_PTR_W-1:0]     entry_count;

    csr_entry_t pending_entries[$];

    int error_count = 0;
    int points_sent = 0;
    int entries_checked = 0;
    int reg_writes = 0;
    int source_gap_pct = 0;
    int sink_stall_pct = 0;
    int stall_left = 0;

    always #10 clk = ~clk;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [DATA_W-1:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [6:0] pick_dim();
        if ($urandom_range(0, 19) == 0)
        begin
            case ($urandom_range(0, 2))
                0: return 7'd0;
                1: return 7'd64;
                default: return 7'd127;
            endcase
        end
        return 7'($urandom_range(1, 4));
    endfunction

    function automatic int eff_dim(input logic [6:0] d);
        if (d == 0)
            return 1;
        if (d > GRID_LIMIT)
            return GRID_LIMIT;
        return d;
    endfunction

    function automatic void restart_frame();
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        entry_count = '0;
    endfunction

    // Computes the CSR row of the current grid point and queues its entries.
    function automatic void build_row(input logic signed [DATA_W-1:0] pot);
        int         nx;
        int         ny;
        int         nz;
        int         h;
        int         w;
        int         xi;
        int         yi;
        int         zi;
        int         sidx;
        longint     acc;
        csr_entry_t held;
        bit         have_held;
        nx = eff_dim(dim_x_reg);
        ny = eff_dim(dim_y_reg);
        nz = eff_dim(dim_z_reg);
        // The half width is width / 2, capped at one, so 0 acts as 1 and 2 as 3.
        h = (width_reg >= 2) ? 1 : 0;
        w = 2 * h + 1;
        have_held = 1'b0;
        for (int dx = -h; dx <= h; dx++)
        begin
            xi = pos_x + dx;
            if (xi < 0 || xi >= nx)
                continue;
            for (int dy = -h; dy <= h; dy++)
            begin
                yi = pos_y + dy;
                if (yi < 0 || yi >= ny)
                    continue;
                for (int dz = -h; dz <= h; dz++)
                begin
                    zi = pos_z + dz;
                    if (zi < 0 || zi >= nz)
                        continue;
                    sidx = ((dx + h) * w + (dy + h)) * w + (dz + h);
                    acc = longint'(scale_reg) * longint'(stencil_coef[sidx]);
                    // Divide by four into Q16.16, rounding halves toward +infinity.
                    acc = (acc + 64'sd131072) >>> 18;
                    if (dx == 0 && dy == 0 && dz == 0)
                        acc += longint'(pot);
                    if (acc > 64'sd2147483647)
                        acc = 64'sd2147483647;
                    else if (acc < -64'sd2147483648)
                        acc = -64'sd2147483648;
                    if (have_held)
                        pending_entries.push_back(held);
                    held.column = COLUMN_W'((xi * ny + yi) * nz + zi + 1);
                    held.value = acc[31:0];
                    held.row_pointer = '0;
                    held.row_last = 1'b0;
                    have_held = 1'b1;
                    entry_count = entry_count + 1'b1;
                end
            end
        end
        // The diagonal is always in bounds, so every row has a last entry.
        held.row_pointer = entry_count + 1'b1;
        held.row_last = 1'b1;
        pending_entries.push_back(held);
        pos_z++;
        if (pos_z >= nz)
        begin
            pos_z = 0;
            pos_y++;
            if (pos_y >= ny)
            begin
                pos_y = 0;
                pos_x++;
                if (pos_x >= nx)
                    restart_frame();
            end
        end
    endfunction

    function automatic grid_item_t load_item(input int idx, input logic [DATA_W-1:0] value);
        grid_item_t it;
        it.kind = KIND_LOAD;
        it.coef_index = INDEX_W'(idx);
        it.coef_value = value;
        it.potential = $urandom();
        return it;
    endfunction

    function automatic grid_item_t point_item(input logic [DATA_W-1:0] pot);
        grid_item_t it;
        it.kind = KIND_POINT;
        it.coef_index = INDEX_W'($urandom());
        it.coef_value = $urandom();
        it.potential = pot;
        return it;
    endfunction

    task automatic send_item(input grid_item_t it);
        int gap;
        gap = ($urandom_range(0, 99) < source_gap_pct) ? pick_gap() : 0;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= it.kind;
        item_ch.coef_index <= it.coef_index;
        item_ch.coef_value <= it.coef_value;
        item_ch.potential <= it.potential;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (it.kind == KIND_LOAD)
        begin
            if (it.coef_index < STENCIL_DEPTH)
                stencil_coef[it.coef_index] = it.coef_value;
        end
        else
        begin
            build_row(it.potential);
            points_sent++;
        end
    endtask

    // Loads cause no entries, so a drain wait after the queue empties covers one still in flight.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic cfg_write(input logic [2:0] reg_idx, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] stored;
        case (reg_idx)
            REG_DIM_X:
            begin
                dim_x_reg = data[6:0];
                stored = DATA_W'(data[6:0]);
                restart_frame();
            end
            REG_DIM_Y:
            begin
                dim_y_reg = data[6:0];
                stored = DATA_W'(data[6:0]);
                restart_frame();
            end
            REG_DIM_Z:
            begin
                dim_z_reg = data[6:0];
                stored = DATA_W'(data[6:0]);
                restart_frame();
            end
            REG_STENCIL_WIDTH:
            begin
                width_reg = data[1:0];
                stored = DATA_W'(data[1:0]);
                restart_frame();
            end
            default:
            begin
                scale_reg = data;
                stored = data;
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== stored)
            note_error($sformatf("register %0d read back %h, expected %h",
                                 reg_idx, prdata, stored));
        psel <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_geometry(input logic [6:0] nx, input logic [6:0] ny,
                                input logic [6:0] nz, input logic [1:0] width);
        wait_idle();
        cfg_write(REG_DIM_X, nx);
        cfg_write(REG_DIM_Y, ny);
        cfg_write(REG_DIM_Z, nz);
        cfg_write(REG_STENCIL_WIDTH, width);
    endtask

    // After reset the grid is one point, so only the center coefficient is read.
    task automatic test_reset_defaults();
        send_item(load_item(CENTER_INDEX, 32'h0002_0000));
        send_item(load_item(31, $urandom()));
        send_item(point_item(32'h0001_0000));
    endtask

    task automatic test_load_stencil();
        for (int i = 0; i < STENCIL_DEPTH; i++)
            send_item(load_item(i, pick_q16()));
    endtask

    task automatic test_rounding();
        wait_idle();
        cfg_write(REG_KINETIC_SCALE, 32'd1);
        send_item(load_item(CENTER_INDEX, 32'h0002_0000));
        send_item(point_item(32'd0));
        send_item(load_item(CENTER_INDEX, -32'sh0002_0000));
        send_item(point_item(32'd0));
        send_item(load_item(CENTER_INDEX, -32'sh0006_0000));
        send_item(point_item(32'd0));
    endtask

    task automatic test_saturation();
        wait_idle();
        cfg_write(REG_KINETIC_SCALE, 32'h7FFF_FFFF);
        send_item(load_item(CENTER_INDEX, 32'h7FFF_FFFF));
        send_item(point_item(32'h7FFF_FFFF));
        send_item(load_item(CENTER_INDEX, 32'h8000_0000));
        send_item(point_item(32'h8000_0000));
        wait_idle();
        cfg_write(REG_KINETIC_SCALE, 32'h8000_0000);
        send_item(point_item(32'h8000_0000));
    endtask

    task automatic test_stencil_widths();
        for (int wd = 0; wd < 4; wd++)
        begin
            set_geometry(7'd2, 7'd2, 7'd2, 2'(wd));
            send_item(point_item(pick_q16()));
        end
    endtask

    task automatic test_dim_clamp();
        set_geometry(7'd0, 7'd127, 7'd1, 2'd3);
        send_item(point_item(pick_q16()));
        send_item(point_item(pick_q16()));
        set_geometry(7'd64, 7'd64, 7'd64, 2'd3);
        send_item(point_item(pick_q16()));
    endtask

    task automatic test_frame_wrap();
        set_geometry(7'd2, 7'd1, 7'd2, 2'd3);
        repeat (6) send_item(point_item(pick_q16()));
    endtask

    task automatic test_random_traffic();
        int sent;
        int frame;
        int burst;
        int idx;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    source_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    source_gap_pct = 30;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    source_gap_pct = 0;
                    sink_stall_pct = 40;
                end
                default:
                begin
                    source_gap_pct = 25;
                    sink_stall_pct = 25;
                end
            endcase
            if ($urandom_range(0, 9) < 7)
                set_geometry(pick_dim(), pick_dim(), pick_dim(), 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                cfg_write(REG_KINETIC_SCALE, pick_q16());
            end
            frame = eff_dim(dim_x_reg) * eff_dim(dim_y_reg) * eff_dim(dim_z_reg);
            if (frame <= STENCIL_DEPTH && $urandom_range(0, 1) == 1)
                burst = frame + $urandom_range(0, 2);
            else
                burst = $urandom_range(3, 15);
            repeat (burst)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    idx = $urandom_range(0, 31);
                    send_item(load_item(idx, pick_q16()));
                    if (idx < STENCIL_DEPTH)
                        sent++;
                end
                send_item(point_item(pick_q16()));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            entry_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            entry_ch.ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
            entry_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_entries
        csr_entry_t want;
        if (rst_n && entry_ch.valid && entry_ch.ready)
        begin
            entries_checked++;
            if (pending_entries.size() == 0)
                note_error($sformatf("unexpected entry: column %0d value %h",
                                     entry_ch.column, entry_ch.entry_value));
            else
            begin
                want = pending_entries.pop_front();
                if (entry_ch.column !== want.column || entry_ch.entry_value !== want.value ||
                    entry_ch.row_pointer !== want.row_pointer ||
                    entry_ch.row_last !== want.row_last)
                    note_error($sformatf({"entry %0d mismatch: expected col %0d val %h ",
                                          "ptr %0d last %0b, got col %0d val %h ptr %0d last %0b"},
                                         entries_checked, want.column, want.value,
                                         want.row_pointer, want.row_last, entry_ch.column,
                                         entry_ch.entry_value, entry_ch.row_pointer,
                                         entry_ch.row_last));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timed out with %0d entries outstanding", pending_entries.size());
        $display("FAIL stencil_to_csr_row_generator_core");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_LOAD;
        item_ch.coef_index = '0;
        item_ch.coef_value = '0;
        item_ch.potential = '0;
        entry_ch.ready = 1'b0;
        dim_x_reg = 7'd1;
        dim_y_reg = 7'd1;
        dim_z_reg = 7'd1;
        width_reg = 2'd3;
        scale_reg = 32'sh0001_0000;
        foreach (stencil_coef[i])
            stencil_coef[i] = '0;
        restart_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_load_stencil();
        test_rounding();
        test_saturation();
        test_stencil_widths();
        test_dim_clamp();
        test_frame_wrap();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d grid points and checked %0d matrix entries over %0d register writes.",
                 points_sent, entries_checked, reg_writes);
        $display("Grids ran from one point up to 64 per axis, with stencil widths 0 to 3.");
        if (error_count == 0)
            $display("PASS stencil_to_csr_row_generator_core");
        else
            $display("FAIL stencil_to_csr_row_generator_core");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/s2csr_pkg.sv
src/s2csr_if.sv
src/s2csr_datapath.sv
src/stencil_to_csr_row_generator_core.sv
verif/tb_top.sv
